>>> design/c2r_pkg.sv
// ----------------------------------------------------------------------------
// c2r_pkg
// Shared types, codes and constants of the multi-channel convolution block.
// ----------------------------------------------------------------------------
package c2r_pkg;

   localparam int DEF_MAX_HEIGHT   = 64;
   localparam int DEF_MAX_WIDTH    = 64;
   localparam int DEF_MAX_CHANNELS = 16;
   localparam int DEF_MAX_KERNEL   = 7;
   localparam int DEF_MAX_MAPS     = 16;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 64;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;
   localparam int VALUE_W     = 16;
   localparam int PROD_W      = 32;
   localparam int SUM_W       = 48;
   localparam int CENTER_W    = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_STRIDE  = 8;

   localparam logic [MODE_W-1:0] MODE_LOAD_PIXEL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_WEIGHT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE     = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAP_HEIGHT    = 3'd0,
      REG_MAP_WIDTH     = 3'd1,
      REG_CHANNEL_COUNT = 3'd2,
      REG_KERNEL_SIZE   = 3'd3,
      REG_STRIDE        = 3'd4,
      REG_PAD_ENABLE    = 3'd5,
      REG_RELU_ENABLE   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_PIXEL  = 2'd0,
      CMD_WEIGHT = 2'd1,
      CMD_CONV   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [3:0]          channel;
      logic [5:0]          row;
      logic [5:0]          col;
      logic [3:0]          out_map;
      logic [2:0]          tap_row;
      logic [2:0]          tap_col;
      logic [VALUE_W-1:0]  value;
      logic [6:0]          ci;
      logic [6:0]          cj;
   } cmd_type;

   typedef struct packed {
      logic [6:0] height;
      logic [6:0] width;
      logic [4:0] chans;
      logic [2:0] ksize;
      logic [1:0] half;
      logic       relu;
   } geom_type;

   typedef struct packed {
      logic busy;
      logic pop;
      logic feat_we;
      logic wgt_we;
   } back_stat_type;

endpackage

>>> design/c2r_ram.sv
// ----------------------------------------------------------------------------
// c2r_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c2r_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/c2r_queue.sv
// ----------------------------------------------------------------------------
// c2r_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module c2r_queue import c2r_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/c2r_front.sv
// ----------------------------------------------------------------------------
// c2r_front
// Control registers, request intake and classification: range-checks loads,
// places the window centre and drops compute requests that give no result.
// ----------------------------------------------------------------------------
module c2r_front import c2r_pkg::*; #(
   parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_MAPS     = DEF_MAX_MAPS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   q_full,
   output logic                   q_push,
   output cmd_type                q_cmd,
   output geom_type               geom
);

   logic [6:0] height_ff, height_in;
   logic [6:0] width_ff, width_in;
   logic [4:0] chans_ff, chans_in;
   logic [2:0] ksize_ff, ksize_in;
   logic [3:0] stride_ff, stride_in;
   logic       pad_ff, pad_in;
   logic       relu_ff, relu_in;

   logic [3:0]          f_channel;
   logic [5:0]          f_row;
   logic [5:0]          f_col;
   logic [3:0]          f_map;
   logic [2:0]          f_tap_row;
   logic [2:0]          f_tap_col;
   logic [VALUE_W-1:0]  f_value;
   logic [3:0]          stride_c;
   logic [CENTER_W-1:0] ci_full, cj_full;
   logic                centre_ok, border, keep;
   cmd_kind_type        kind;

   assign f_channel = req_tdata[3:0];
   assign f_row     = req_tdata[9:4];
   assign f_col     = req_tdata[15:10];
   assign f_map     = req_tdata[19:16];
   assign f_tap_row = req_tdata[22:20];
   assign f_tap_col = req_tdata[25:23];
   assign f_value   = req_tdata[41:26];

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      chans_in  = chans_ff;
      ksize_in  = ksize_ff;
      stride_in = stride_ff;
      pad_in    = pad_ff;
      relu_in   = relu_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MAP_HEIGHT:    height_in = csr_wdata[6:0];
            REG_MAP_WIDTH:     width_in  = csr_wdata[6:0];
            REG_CHANNEL_COUNT: chans_in  = csr_wdata[4:0];
            REG_KERNEL_SIZE:   ksize_in  = csr_wdata[2:0];
            REG_STRIDE:        stride_in = csr_wdata[3:0];
            REG_PAD_ENABLE:    pad_in    = csr_wdata[0];
            REG_RELU_ENABLE:   relu_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 7'd64;
         width_ff  <= 7'd64;
         chans_ff  <= 5'd1;
         ksize_ff  <= 3'd3;
         stride_ff <= 4'd1;
         pad_ff    <= 1'b1;
         relu_ff   <= 1'b1;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         chans_ff  <= chans_in;
         ksize_ff  <= ksize_in;
         stride_ff <= stride_in;
         pad_ff    <= pad_in;
         relu_ff   <= relu_in;
      end
   end

   // saturate register values to the supported ranges
   always_comb begin
      geom.height = (height_ff == '0) ? 7'd1 :
                    (int'(height_ff) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_ff;
      geom.width  = (width_ff == '0) ? 7'd1 :
                    (int'(width_ff) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_ff;
      geom.chans  = (chans_ff == '0) ? 5'd1 :
                    (int'(chans_ff) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : chans_ff;
      geom.ksize  = (ksize_ff == '0) ? 3'd1 :
                    (int'(ksize_ff) > MAX_KERNEL) ? 3'(MAX_KERNEL) : ksize_ff;
      geom.half   = geom.ksize[2:1];
      geom.relu   = relu_ff;
      stride_c    = (stride_ff == '0) ? 4'd1 :
                    (int'(stride_ff) > MAX_STRIDE) ? 4'(MAX_STRIDE) : stride_ff;
   end

   always_comb begin
      ci_full   = CENTER_W'(f_row) * CENTER_W'(stride_c);
      cj_full   = CENTER_W'(f_col) * CENTER_W'(stride_c);
      centre_ok = (ci_full < CENTER_W'(geom.height)) && (cj_full < CENTER_W'(geom.width));
      border    = (ci_full < CENTER_W'(geom.half)) || (cj_full < CENTER_W'(geom.half)) ||
                  (ci_full + CENTER_W'(geom.half) >= CENTER_W'(geom.height)) ||
                  (cj_full + CENTER_W'(geom.half) >= CENTER_W'(geom.width));
      keep = 1'b0;
      kind = CMD_CONV;
      case (req_tuser)
         MODE_LOAD_PIXEL: begin
            kind = CMD_PIXEL;
            keep = (int'(f_channel) < MAX_CHANNELS) && (int'(f_row) < MAX_HEIGHT) &&
                   (int'(f_col) < MAX_WIDTH);
         end
         MODE_LOAD_WEIGHT: begin
            kind = CMD_WEIGHT;
            keep = (int'(f_map) < MAX_MAPS) && (int'(f_channel) < MAX_CHANNELS) &&
                   (int'(f_tap_row) < MAX_KERNEL) && (int'(f_tap_col) < MAX_KERNEL);
         end
         MODE_COMPUTE: begin
            kind = CMD_CONV;
            keep = (int'(f_map) < MAX_MAPS) && centre_ok && (!border || pad_ff);
         end
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      q_cmd.kind    = kind;
      q_cmd.channel = f_channel;
      q_cmd.row     = f_row;
      q_cmd.col     = f_col;
      q_cmd.out_map = f_map;
      q_cmd.tap_row = f_tap_row;
      q_cmd.tap_col = f_tap_col;
      q_cmd.value   = f_value;
      q_cmd.ci      = ci_full[6:0];
      q_cmd.cj      = cj_full[6:0];
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;

endmodule

>>> design/c2r_back.sv
// ----------------------------------------------------------------------------
// c2r_back
// Command execution: writes loads into the feature and weight stores and walks
// channels and kernel taps of a compute through one pipelined MAC.
// ----------------------------------------------------------------------------
module c2r_back import c2r_pkg::*; #(
   parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_MAPS     = DEF_MAX_MAPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   input  geom_type          geom,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_map,
   output logic [5:0]        rsp_row,
   output logic [5:0]        rsp_col,
   output logic [SUM_W-1:0]  rsp_sum,
   output back_stat_type     stat
);

   localparam int PLANE      = MAX_HEIGHT * MAX_WIDTH;
   localparam int FEAT_DEPTH = MAX_CHANNELS * PLANE;
   localparam int TAPS       = MAX_KERNEL * MAX_KERNEL;
   localparam int WGT_DEPTH  = MAX_MAPS * MAX_CHANNELS * TAPS;
   localparam int FA_W       = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int WA_W       = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                 state_ff, state_in;
   cmd_type                   job_ff, job_in;
   logic [CH_W-1:0]           ch_ff, ch_in;
   logic [2:0]                tr_ff, tr_in;
   logic [2:0]                tc_ff, tc_in;
   logic                      live1_ff, live1_in, ok1_ff, ok1_in;
   logic                      live2_ff, live2_in, ok2_ff, ok2_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_map_ff, rsp_map_in;
   logic [5:0]                rsp_row_ff, rsp_row_in;
   logic [5:0]                rsp_col_ff, rsp_col_in;
   logic [SUM_W-1:0]          rsp_sum_ff, rsp_sum_in;

   logic                      feat_we, wgt_we;
   logic [FA_W-1:0]           feat_wr_addr, feat_rd_addr;
   logic [WA_W-1:0]           wgt_wr_addr, wgt_rd_addr;
   logic [VALUE_W-1:0]        feat_rd_data, wgt_rd_data;
   logic [9:0]                pr, pc;
   logic                      tap_ok, last_tc, last_tr, last_ch, out_free;

   c2r_ram #(.WIDTH(VALUE_W), .DEPTH(FEAT_DEPTH)) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (feat_wr_addr),
      .wr_data (q_cmd.value),
      .rd_addr (feat_rd_addr),
      .rd_data (feat_rd_data)
   );

   c2r_ram #(.WIDTH(VALUE_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_addr (wgt_wr_addr),
      .wr_data (q_cmd.value),
      .rd_addr (wgt_rd_addr),
      .rd_data (wgt_rd_data)
   );

   always_comb begin
      pr      = 10'(job_ff.ci) - 10'(geom.half) + 10'(tr_ff);
      pc      = 10'(job_ff.cj) - 10'(geom.half) + 10'(tc_ff);
      tap_ok  = !pr[9] && (pr[8:0] < 9'(geom.height)) && !pc[9] && (pc[8:0] < 9'(geom.width));
      last_tc = (tc_ff == geom.ksize - 3'd1);
      last_tr = (tr_ff == geom.ksize - 3'd1);
      last_ch = (int'(ch_ff) == int'(geom.chans) - 1);

      feat_rd_addr = FA_W'(int'(ch_ff) * PLANE + int'(pr[8:0]) * MAX_WIDTH + int'(pc[8:0]));
      wgt_rd_addr  = WA_W'((int'(job_ff.out_map) * MAX_CHANNELS + int'(ch_ff)) * TAPS +
                           int'(tr_ff) * MAX_KERNEL + int'(tc_ff));
      feat_wr_addr = FA_W'(int'(q_cmd.channel) * PLANE + int'(q_cmd.row) * MAX_WIDTH +
                           int'(q_cmd.col));
      wgt_wr_addr  = WA_W'((int'(q_cmd.out_map) * MAX_CHANNELS + int'(q_cmd.channel)) * TAPS +
                           int'(q_cmd.tap_row) * MAX_KERNEL + int'(q_cmd.tap_col));

      q_pop   = (state_ff == ST_IDLE) && q_valid;
      feat_we = q_pop && (q_cmd.kind == CMD_PIXEL);
      wgt_we  = q_pop && (q_cmd.kind == CMD_WEIGHT);
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      job_in       = job_ff;
      ch_in        = ch_ff;
      tr_in        = tr_ff;
      tc_in        = tc_ff;
      live1_in     = (state_ff == ST_RUN);
      ok1_in       = (state_ff == ST_RUN) && tap_ok;
      live2_in     = live1_ff;
      ok2_in       = ok1_ff;
      prod_in      = $signed(feat_rd_data) * $signed(wgt_rd_data);
      acc_in       = ok2_ff ? acc_ff + SUM_W'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_map_in   = rsp_map_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_sum_in   = rsp_sum_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop && (q_cmd.kind == CMD_CONV)) begin
               job_in   = q_cmd;
               ch_in    = '0;
               tr_in    = '0;
               tc_in    = '0;
               acc_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!last_tc) begin
               tc_in = tc_ff + 3'd1;
            end else begin
               tc_in = '0;
               if (!last_tr) begin
                  tr_in = tr_ff + 3'd1;
               end else begin
                  tr_in = '0;
                  if (last_ch) begin
                     state_in = ST_DRAIN;
                  end else begin
                     ch_in = ch_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!live1_ff && !live2_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_map_in   = job_ff.out_map;
               rsp_row_in   = job_ff.row;
               rsp_col_in   = job_ff.col;
               rsp_sum_in   = (geom.relu && acc_ff[SUM_W-1]) ? '0 : acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live1_ff     <= 1'b0;
         ok1_ff       <= 1'b0;
         live2_ff     <= 1'b0;
         ok2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live1_ff     <= live1_in;
         ok1_ff       <= ok1_in;
         live2_ff     <= live2_in;
         ok2_ff       <= ok2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff     <= job_in;
      ch_ff      <= ch_in;
      tr_ff      <= tr_in;
      tc_ff      <= tc_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_map_ff <= rsp_map_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_map      = rsp_map_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_sum      = rsp_sum_ff;
   assign stat.busy    = (state_ff != ST_IDLE);
   assign stat.pop     = q_pop;
   assign stat.feat_we = feat_we;
   assign stat.wgt_we  = wgt_we;

endmodule

>>> design/conv2d_multichannel_relu.sv
// ----------------------------------------------------------------------------
// conv2d_multichannel_relu
// Multi-channel 2-D convolution with stride, optional zero padding and ReLU.
// ----------------------------------------------------------------------------
// Pixels and weights are loaded one per transaction; a compute transaction
// returns the exact 48-bit sum over all channels and kernel taps of the window
// centred at (row*stride, col*stride), or nothing when the centre lies off the
// map, on the border with padding off, or names an unknown map. The front
// classifies each transaction in its accept cycle and hands it to a four-entry
// command queue, so intake goes on while the back is busy or a result waits.
// The back writes a load into its store as it pops it. A compute walks every
// channel and kernel tap at one multiply-accumulate per cycle, set by the single
// read port of the feature store and of the weight store, through the store read,
// product and accumulator registers, then waits for a free output stage. Both
// stores are undefined until written.
module conv2d_multichannel_relu import c2r_pkg::*; #(
   parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_MAPS     = DEF_MAX_MAPS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode
   input  logic [MODE_W-1:0]      req_tuser,
   // channel, row, col, out_map, tap_row, tap_col, value, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_map, result_row, result_col, conv_sum
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type          push_cmd, head_cmd;
   logic             q_push, q_full, q_pop, q_valid;
   geom_type         geom;
   back_stat_type    stat;
   logic [3:0]       rsp_map;
   logic [5:0]       rsp_row;
   logic [5:0]       rsp_col;
   logic [SUM_W-1:0] rsp_sum;

   c2r_front #(
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_MAPS     (MAX_MAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .geom       (geom)
   );

   c2r_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   c2r_back #(
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_MAPS     (MAX_MAPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .geom      (geom),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_map   (rsp_map),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_sum   (rsp_sum),
      .stat      (stat)
   );

   assign rsp_tdata = {rsp_sum, rsp_col, rsp_row, rsp_map};

   a_single_store_write: assert property (@(posedge clock) disable iff (reset)
      !(stat.feat_we && stat.wgt_we))
      else $error("feature and weight stores written in the same cycle");

   a_load_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      (stat.feat_we || stat.wgt_we) |-> (stat.pop && !stat.busy))
      else $error("store write outside an idle pop");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> q_valid)
      else $error("command popped from empty queue");

   a_result_from_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.busy))
      else $error("result raised without a compute in progress");

endmodule
